/* rtl/ure_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ure_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package ure_pkg;

	localparam int BUF_DEPTH = 16;
	localparam int DIST_BITS = 12;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
	localparam int LOSS_W    = 16;
	localparam int CNT_W     = 24;
	localparam int TRIG_W    = 16;
	localparam int CFG_W     = 24;

	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
	localparam logic [LOSS_W-1:0]    LOSS_MAX = {LOSS_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_ENABLE = 2'd1,
		REQ_READ   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BUSY  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_MODE    = 2'd0,
		CFG_TRIG    = 2'd1,
		CFG_PERIOD  = 2'd2,
		CFG_TPU     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TRIG_IDLE  = 2'd0,
		TRIG_PULSE = 2'd1,
		TRIG_GAP   = 2'd2
	} trig_phase_t;

	typedef struct packed {
		logic              mode;
		logic [TRIG_W-1:0] trigger_ticks;
		logic [CNT_W-1:0]  period_ticks;
		logic [CNT_W-1:0]  ticks_per_unit;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic start;
		logic run_set;
		logic run_clr;
	} trig_cmd_t;

	typedef struct packed {
		logic running;
		logic idle;
		logic level_next;
		logic restart;
	} trig_stat_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} ring_cmd_t;

	typedef struct packed {
		logic              empty;
		logic [FILL_W-1:0] fill_next;
		logic [LOSS_W-1:0] lost_next;
	} ring_stat_t;

endpackage
`default_nettype wire

/* rtl/ure_trigger.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ure_trigger
// Trigger pulse sequencer: pulse high phase, periodic gap, idle.
// ----------------------------------------------------------------------------
module ure_trigger (
	input  wire                      clk,
	input  wire                      arst_n,
	input  ure_pkg::cfg_t            cfg,
	input  ure_pkg::trig_cmd_t       cmd,
	output ure_pkg::trig_stat_t      stat
);
	import ure_pkg::*;

	trig_phase_t        phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               run_q, run_d;
	logic [CNT_W-1:0]   cnt_inc;
	logic               pulse_done, gap_done;

	assign cnt_inc    = cnt_q + 1'b1;
	assign pulse_done = cnt_inc >= {{(CNT_W-TRIG_W){1'b0}}, cfg.trigger_ticks};
	assign gap_done   = cnt_inc >= cfg.period_ticks;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		run_d   = run_q;
		if (cmd.tick) begin
			case (phase_q)
				TRIG_PULSE: begin
					cnt_d = cnt_inc;
					if (pulse_done) begin
						cnt_d   = '0;
						phase_d = run_q ? TRIG_GAP : TRIG_IDLE;
					end
				end
				TRIG_GAP: begin
					cnt_d = cnt_inc;
					if (gap_done) begin
						cnt_d   = '0;
						phase_d = run_q ? TRIG_PULSE : TRIG_IDLE;
					end
				end
				default: phase_d = TRIG_IDLE;
			endcase
		end else begin
			if (cmd.run_set)
				run_d = 1'b1;
			if (cmd.run_clr) begin
				run_d = 1'b0;
				if (phase_q == TRIG_GAP) begin
					phase_d = TRIG_IDLE;
					cnt_d   = '0;
				end
			end
			if (cmd.start) begin
				phase_d = TRIG_PULSE;
				cnt_d   = '0;
			end
		end
	end

	always_comb begin
		stat.running    = run_q;
		stat.idle       = (phase_q == TRIG_IDLE);
		stat.level_next = (phase_d == TRIG_PULSE);
		// gap ran out while still running: new pulse, new measurement
		stat.restart    = cmd.tick && (phase_q == TRIG_GAP) && gap_done && run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= TRIG_IDLE;
			cnt_q   <= '0;
			run_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			run_q   <= run_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/ure_echo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ure_echo
// Echo width meter: counts high ticks in units of ticks_per_unit.
// ----------------------------------------------------------------------------
module ure_echo (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire [ure_pkg::CNT_W-1:0]      ticks_per_unit,
	input  wire                           tick,
	input  wire                           level,
	output logic                          fall,
	output logic [ure_pkg::DIST_BITS-1:0] dist_units
);
	import ure_pkg::*;

	logic                 prev_q;
	logic [CNT_W-1:0]     pre_q, pre_d;
	logic [DIST_BITS-1:0] acc_q, acc_d;
	logic [CNT_W-1:0]     div, pre_inc;
	logic [DIST_BITS-1:0] acc_base;

	// zero divisor behaves as one
	assign div        = (ticks_per_unit == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : ticks_per_unit;
	// a rising edge restarts the measurement
	assign pre_inc    = (prev_q ? pre_q : '0) + 1'b1;
	assign acc_base   = prev_q ? acc_q : '0;
	assign fall       = tick && !level && prev_q;
	assign dist_units = acc_q;

	always_comb begin
		pre_d = pre_q;
		acc_d = acc_q;
		if (tick && level) begin
			if (pre_inc >= div) begin
				pre_d = '0;
				acc_d = (acc_base == DIST_MAX) ? acc_base : acc_base + 1'b1;
			end else begin
				pre_d = pre_inc;
				acc_d = acc_base;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			pre_q  <= '0;
			acc_q  <= '0;
		end else begin
			pre_q <= pre_d;
			acc_q <= acc_d;
			if (tick)
				prev_q <= level;
		end
	end

endmodule
`default_nettype wire

/* rtl/ure_ring.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ure_ring
// Measurement ring buffer with overwrite of the oldest entry and loss count.
// ----------------------------------------------------------------------------
module ure_ring (
	input  wire                           clk,
	input  wire                           arst_n,
	input  ure_pkg::ring_cmd_t            cmd,
	input  wire [ure_pkg::DIST_BITS-1:0]  wr_data,
	output logic [ure_pkg::DIST_BITS-1:0] rd_data,
	output ure_pkg::ring_stat_t           stat
);
	import ure_pkg::*;

	logic [DIST_BITS-1:0] mem [BUF_DEPTH];
	logic [IDX_W-1:0]     head_q, head_d, tail_q, tail_d;
	logic [FILL_W-1:0]    fill_q, fill_d;
	logic [LOSS_W-1:0]    lost_q, lost_d;
	logic                 full;

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
		nxt = (i == IDX_W'(BUF_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign full = (fill_q == FILL_W'(BUF_DEPTH));

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		fill_d = fill_q;
		lost_d = lost_q;
		if (cmd.clear) begin
			head_d = '0;
			tail_d = '0;
			fill_d = '0;
			lost_d = '0;
		end else if (cmd.push) begin
			tail_d = nxt(tail_q);
			if (full) begin
				head_d = nxt(head_q);
				if (lost_q != LOSS_MAX)
					lost_d = lost_q + 1'b1;
			end else begin
				fill_d = fill_q + 1'b1;
			end
		end else if (cmd.pop) begin
			head_d = nxt(head_q);
			fill_d = fill_q - 1'b1;
		end
	end

	always_comb begin
		stat.empty     = (fill_q == '0);
		stat.fill_next = fill_d;
		stat.lost_next = lost_d;
	end

	// popped entry is registered and held until the next pop
	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.clear)
			mem[tail_q] <= wr_data;
		if (cmd.pop)
			rd_data <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			lost_q <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_d;
			lost_q <= lost_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/ultrasonic_echo_ranger.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger pulse generator, echo width meter and measurement ring buffer.
// Pipeline: an accepted beat passes the input register (s1), then the result
//   register; state is updated in the cycle the item leaves s1.
// Throughput: one beat per cycle while out_stall is low; the output register
//   lets a new beat be taken while a result is waiting.
// Reset: arst_n clears all control state, config returns to its defaults.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [1:0]                     cfg_index,
	input  wire [ure_pkg::CFG_W-1:0]      cfg_data,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [1:0]                     req_type,
	input  wire                           echo_level,
	input  wire                           enable_value,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          trigger_level,
	output logic                          read_valid,
	output logic [ure_pkg::DIST_BITS-1:0] read_distance,
	output logic [ure_pkg::FILL_W-1:0]    entries,
	output logic [ure_pkg::LOSS_W-1:0]    loss_count,
	output logic                          busy_res,
	output logic [1:0]                    status
);
	import ure_pkg::*;

	cfg_t                 cfg_q;
	logic                 valid_s1;
	logic [1:0]           req_s1;
	logic                 echo_s1, en_s1;
	logic                 res_valid_q;
	logic                 ongoing_q, ongoing_d;
	logic                 adv, proc;
	trig_cmd_t            tcmd;
	trig_stat_t           tstat;
	ring_cmd_t            rcmd;
	ring_stat_t           rstat;
	logic                 fall;
	logic [DIST_BITS-1:0] meas, rd_data;
	status_t              st_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= 1'b0;
			cfg_q.trigger_ticks  <= TRIG_W'(20);
			cfg_q.period_ticks   <= CNT_W'(100000);
			cfg_q.ticks_per_unit <= CNT_W'(58);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODE:   cfg_q.mode           <= cfg_data[0];
				CFG_TRIG:   cfg_q.trigger_ticks  <= cfg_data[TRIG_W-1:0];
				CFG_PERIOD: cfg_q.period_ticks   <= cfg_data[CNT_W-1:0];
				CFG_TPU:    cfg_q.ticks_per_unit <= cfg_data[CNT_W-1:0];
				default:    ;
			endcase
		end
	end

	// s1 drains whenever the result register is free or being taken
	assign adv      = !res_valid_q || !out_stall;
	assign proc     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1  <= req_type;
			echo_s1 <= echo_level;
			en_s1   <= enable_value;
		end
	end

	always_comb begin
		tcmd      = '0;
		rcmd      = '0;
		st_d      = ST_OK;
		ongoing_d = ongoing_q;
		if (proc) begin
			case (req_t'(req_s1))
				REQ_TICK: begin
					tcmd.tick = 1'b1;
					rcmd.push = fall;
					if (tstat.restart)
						ongoing_d = 1'b1;
					else if (fall)
						ongoing_d = 1'b0;
				end
				REQ_ENABLE: begin
					if (!cfg_q.mode) begin
						if (ongoing_q) begin
							st_d = ST_BUSY;
						end else begin
							rcmd.clear = en_s1;
							tcmd.start = 1'b1;
							ongoing_d  = 1'b1;
						end
					end else if (en_s1) begin
						if (!tstat.running) begin
							tcmd.run_set = 1'b1;
							if (tstat.idle) begin
								tcmd.start = 1'b1;
								ongoing_d  = 1'b1;
							end
						end
					end else begin
						tcmd.run_clr = 1'b1;
					end
				end
				REQ_READ: begin
					if (rstat.empty) begin
						st_d = ST_EMPTY;
						if (!ongoing_q) begin
							tcmd.start = 1'b1;
							ongoing_d  = 1'b1;
						end
					end else begin
						rcmd.pop = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ongoing_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			ongoing_q <= ongoing_d;
			if (adv)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			trigger_level <= tstat.level_next;
			read_valid    <= rcmd.pop;
			entries       <= rstat.fill_next;
			loss_count    <= rstat.lost_next;
			busy_res      <= ongoing_d;
			status        <= st_d;
		end
	end

	// ring holds the popped entry in its read register until the next pop
	assign read_distance = read_valid ? rd_data : '0;

	assign out_valid = res_valid_q;

	ure_trigger u_trigger (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (tcmd),
		.stat   (tstat)
	);

	ure_echo u_echo (
		.clk            (clk),
		.arst_n         (arst_n),
		.ticks_per_unit (cfg_q.ticks_per_unit),
		.tick           (tcmd.tick),
		.level          (echo_s1),
		.fall           (fall),
		.dist_units     (meas)
	);

	ure_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (rcmd),
		.wr_data (meas),
		.rd_data (rd_data),
		.stat    (rstat)
	);

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> status == ST_OK)
		else $error("popped beat reports a non-ok status");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		proc && req_s1 == REQ_READ && rstat.empty |=> status == ST_EMPTY && !read_valid)
		else $error("read of empty ring not flagged");

	a_busy_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BUSY |-> busy_res)
		else $error("enable refused while no measurement ongoing");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries <= FILL_W'(BUF_DEPTH))
		else $error("ring fill count beyond depth");

endmodule
`default_nettype wire
